[sv/svn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package svn_pkg;

	// Mesh size and derived address width.
	localparam int MAX_VERTICES = 1024;
	localparam int VTX_ADDR_W = $clog2(MAX_VERTICES);

	// Field widths.
	localparam int POS_W = 24;
	localparam int ACC_W = 24;
	localparam int NRM_W = 16;
	localparam int MAG_W = 51;
	localparam int THR_W = 32;

	// Memory entry widths: the vertex entry carries a loaded flag on top.
	localparam int VTX_MEM_W = 3 * POS_W + 1;
	localparam int ACC_MEM_W = 3 * ACC_W;

	// Unit length in the normal format.
	localparam logic [NRM_W-1:0] UNIT = 16'd16384;

	// Function codes.
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_TRI  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Top level sequencer states.
	typedef enum logic [3:0] {
		T_IDLE,
		T_LOAD,
		T_VRD,
		T_VCAP,
		T_VCHK,
		T_XMUL,
		T_NSTART,
		T_NORM,
		T_ARD,
		T_AWR,
		T_RRD,
		T_RCHK,
		T_FIN
	} top_state_t;

	// Normalizer states.
	typedef enum logic [3:0] {
		N_IDLE,
		N_CHK,
		N_DSQ,
		N_DCMP,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DIVI,
		N_DIV,
		N_DONE
	} norm_state_t;

	// Result handed back by the normalizer.
	typedef struct packed {
		logic                    done;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
	} norm_res_t;

endpackage
`default_nettype wire

[sv/smooth_vertex_normals_core.sv]
// Smoothed vertex normal engine.
// Input channel (in_valid / in_stall): one transaction carries func, a vertex
// index with a position, and three triangle corners. Output channel
// (out_valid / out_stall): one transaction per input with a unit normal and a
// status bit. cfg_wr_en / cfg_wr_data write the degenerate threshold; the
// user must write it only while idle, as the block does not enforce this.
// Items are processed one at a time. A triangle fetches and checks its
// corners, forms the cross product on the shared 25x25 multiplier, runs the
// normalizer, then updates the accumulators. The normalizer tests short
// vectors against the threshold, then shifts all components one bit per step
// until the largest lies in the 2^20 range (up to 28 steps), then runs the
// square root digit loop and the bit-serial divider.
// After reset a clearing pass writes all 1024 vertex entries as not loaded;
// in_stall stays high meanwhile. A finished result sits in the output
// register while out_stall is high; the next item can be accepted meanwhile
// and is held at completion until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module smooth_vertex_normals_core
	import svn_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [THR_W-1:0]        cfg_wr_data,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              func,
	input  wire logic [VTX_ADDR_W-1:0]   vertex_index,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic [VTX_ADDR_W-1:0]   corner_a,
	input  wire logic [VTX_ADDR_W-1:0]   corner_b,
	input  wire logic [VTX_ADDR_W-1:0]   corner_c,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [NRM_W-1:0]      normal_x,
	output logic signed [NRM_W-1:0]      normal_y,
	output logic signed [NRM_W-1:0]      normal_z,
	output logic                         status
);

	top_state_t state_q, state_d;

	logic [THR_W-1:0]        thr_q;
	logic                    clr_q;
	logic [VTX_ADDR_W-1:0]   clr_cnt_q;
	logic [1:0]              func_q;
	logic [VTX_ADDR_W-1:0]   vi_q;
	logic [3*POS_W-1:0]      pos_q;
	logic [VTX_ADDR_W-1:0]   corner_q [3];
	logic [1:0]              k_q;
	logic [2:0]              xcnt_q;
	logic signed [POS_W-1:0] v_q [3][3];
	logic                    ld_q [3];
	logic signed [49:0]      p_q;
	logic signed [MAG_W-1:0] cr_q [3];
	logic signed [NRM_W-1:0] f_q [3];
	logic signed [NRM_W-1:0] rn_q [3];
	logic                    st_q;

	// Memory ports.
	logic                    vm_en, vm_we;
	logic [VTX_ADDR_W-1:0]   vm_addr;
	logic [VTX_MEM_W-1:0]    vm_wdata, vm_rdata;
	logic                    am_en, am_we;
	logic [VTX_ADDR_W-1:0]   am_addr;
	logic [ACC_MEM_W-1:0]    am_wdata, am_rdata;

	logic                    accept;
	logic                    out_load;
	logic                    norm_start;
	logic signed [MAG_W-1:0] nc [3];
	norm_res_t               nres;
	logic signed [POS_W:0]   e1 [3];
	logic signed [POS_W:0]   e2 [3];
	logic signed [POS_W:0]   ma, mb;
	logic signed [49:0]      xprod;
	logic signed [ACC_W-1:0] acc [3];
	logic signed [ACC_W:0]   sum [3];
	logic [ACC_W-1:0]        sat [3];

	assign accept   = in_valid && !in_stall;
	assign in_stall = clr_q || (state_q != T_IDLE);
	assign out_load = (state_q == T_FIN) && (!out_valid || !out_stall);

	// Edge vectors and the shared cross product multiplier.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = (POS_W+1)'(v_q[1][i]) - (POS_W+1)'(v_q[0][i]);
			e2[i] = (POS_W+1)'(v_q[2][i]) - (POS_W+1)'(v_q[0][i]);
		end
		case (xcnt_q)
			3'd0:    begin ma = e1[1]; mb = e2[2]; end
			3'd1:    begin ma = e1[2]; mb = e2[1]; end
			3'd2:    begin ma = e1[2]; mb = e2[0]; end
			3'd3:    begin ma = e1[0]; mb = e2[2]; end
			3'd4:    begin ma = e1[0]; mb = e2[1]; end
			default: begin ma = e1[1]; mb = e2[0]; end
		endcase
		xprod = ma * mb;
	end

	// Saturating accumulator update.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = am_rdata[ACC_W*(2-i) +: ACC_W];
			sum[i] = (ACC_W+1)'(acc[i]) + (ACC_W+1)'(f_q[i]);
			if (sum[i][ACC_W] != sum[i][ACC_W-1]) begin
				sat[i] = sum[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			end else begin
				sat[i] = sum[i][ACC_W-1:0];
			end
		end
	end

	// Normalizer operands: the accumulator on a read, the cross product else.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nc[i] = (func_q == FUNC_READ) ? MAG_W'(acc[i]) : cr_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			thr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + VTX_ADDR_W'(1);
				if (clr_cnt_q == '1) clr_q <= 1'b0;
			end
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d    = state_q;
		vm_en      = 1'b0;
		vm_we      = 1'b0;
		vm_addr    = vi_q;
		vm_wdata   = {1'b1, pos_q};
		am_en      = 1'b0;
		am_we      = 1'b0;
		am_addr    = vi_q;
		am_wdata   = '0;
		norm_start = 1'b0;
		if (clr_q) begin
			vm_en    = 1'b1;
			vm_we    = 1'b1;
			vm_addr  = clr_cnt_q;
			vm_wdata = '0;
		end
		unique case (state_q)
			T_IDLE: begin
				if (accept) begin
					unique case (func)
						FUNC_LOAD: state_d = T_LOAD;
						FUNC_TRI:  state_d = T_VRD;
						FUNC_READ: state_d = T_RRD;
						default:   state_d = T_FIN;
					endcase
				end
			end
			T_LOAD: begin
				vm_en   = 1'b1;
				vm_we   = 1'b1;
				am_en   = 1'b1;
				am_we   = 1'b1;
				state_d = T_FIN;
			end
			T_VRD: begin
				vm_en   = 1'b1;
				vm_addr = corner_q[k_q];
				state_d = T_VCAP;
			end
			T_VCAP:   state_d = (k_q == 2'd2) ? T_VCHK : T_VRD;
			T_VCHK:   state_d = (ld_q[0] && ld_q[1] && ld_q[2]) ? T_XMUL : T_FIN;
			T_XMUL:   if (xcnt_q == 3'd5) state_d = T_NSTART;
			T_NSTART: begin
				norm_start = 1'b1;
				state_d    = T_NORM;
			end
			T_NORM: begin
				if (nres.done) state_d = (func_q == FUNC_READ) ? T_FIN : T_ARD;
			end
			T_ARD: begin
				am_en   = 1'b1;
				am_addr = corner_q[k_q];
				state_d = T_AWR;
			end
			T_AWR: begin
				am_en    = 1'b1;
				am_we    = 1'b1;
				am_addr  = corner_q[k_q];
				am_wdata = {sat[0], sat[1], sat[2]};
				state_d  = (k_q == 2'd2) ? T_FIN : T_ARD;
			end
			T_RRD: begin
				vm_en   = 1'b1;
				am_en   = 1'b1;
				state_d = T_RCHK;
			end
			T_RCHK:   state_d = vm_rdata[VTX_MEM_W-1] ? T_NSTART : T_FIN;
			T_FIN:    if (out_load) state_d = T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				func_q      <= func;
				vi_q        <= vertex_index;
				pos_q       <= {pos_x, pos_y, pos_z};
				corner_q[0] <= corner_a;
				corner_q[1] <= corner_b;
				corner_q[2] <= corner_c;
				k_q         <= 2'd0;
				xcnt_q      <= 3'd0;
				st_q        <= STATUS_ERR;
				for (int i = 0; i < 3; i++) rn_q[i] <= '0;
			end
			T_LOAD: st_q <= STATUS_OK;
			T_VCAP: begin
				ld_q[k_q]    <= vm_rdata[VTX_MEM_W-1];
				v_q[k_q][0]  <= vm_rdata[2*POS_W +: POS_W];
				v_q[k_q][1]  <= vm_rdata[POS_W +: POS_W];
				v_q[k_q][2]  <= vm_rdata[0 +: POS_W];
				k_q          <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			T_XMUL: begin
				xcnt_q <= xcnt_q + 3'd1;
				if (!xcnt_q[0]) p_q <= xprod;
				else cr_q[xcnt_q[2:1]] <= MAG_W'(p_q) - MAG_W'(xprod);
			end
			T_NORM: begin
				if (nres.done) begin
					if (func_q == FUNC_READ) begin
						rn_q[0] <= nres.nx;
						rn_q[1] <= nres.ny;
						rn_q[2] <= nres.nz;
						st_q    <= STATUS_OK;
					end else begin
						f_q[0] <= nres.nx;
						f_q[1] <= nres.ny;
						f_q[2] <= nres.nz;
					end
				end
			end
			T_AWR: begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2) st_q <= STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			normal_x <= rn_q[0];
			normal_y <= rn_q[1];
			normal_z <= rn_q[2];
			status   <= st_q;
		end
	end

	svn_ram #(.WIDTH(VTX_MEM_W), .ADDR_W(VTX_ADDR_W)) u_vtx_ram (
		.clk   (clk),
		.en    (vm_en),
		.we    (vm_we),
		.addr  (vm_addr),
		.wdata (vm_wdata),
		.rdata (vm_rdata)
	);

	svn_ram #(.WIDTH(ACC_MEM_W), .ADDR_W(VTX_ADDR_W)) u_acc_ram (
		.clk   (clk),
		.en    (am_en),
		.we    (am_we),
		.addr  (am_addr),
		.wdata (am_wdata),
		.rdata (am_rdata)
	);

	svn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.thr    (thr_q),
		.cx     (nc[0]),
		.cy     (nc[1]),
		.cz     (nc[2]),
		.res    (nres)
	);

endmodule
`default_nettype wire

[sv/svn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module svn_ram #(
	parameter int WIDTH  = 72,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	// Single port; read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

[sv/svn_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
module svn_norm
	import svn_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [THR_W-1:0]        thr,
	input  wire logic signed [MAG_W-1:0] cx,
	input  wire logic signed [MAG_W-1:0] cy,
	input  wire logic signed [MAG_W-1:0] cz,
	output norm_res_t                    res
);

	norm_state_t state_q, state_d;

	logic [MAG_W-1:0] m_q [3];
	logic             neg_q [3];
	logic [1:0]       k_q;
	logic [4:0]       cnt_q;
	logic [43:0]      s_q;
	logic [21:0]      root_q;
	logic [25:0]      rem_q;
	logic [21:0]      drem_q;
	logic [15:0]      dlow_q;
	logic [15:0]      dq_q;
	logic [NRM_W-1:0] n_q [3];

	logic [MAG_W-1:0] mx;
	logic [MAG_W-1:0] sel_m;
	logic [41:0]      prod;
	logic [25:0]      rem_next;
	logic [25:0]      trial;
	logic [22:0]      rt;
	logic             qbit;
	logic [15:0]      qn;
	logic [NRM_W-1:0] qc;
	logic [35:0]      num;
	logic             nrm_done;

	// Largest magnitude and the shared squaring multiplier.
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
		case (k_q)
			2'd0:    sel_m = m_q[0];
			2'd1:    sel_m = m_q[1];
			default: sel_m = m_q[2];
		endcase
		prod = sel_m[20:0] * sel_m[20:0];
	end

	// One square-root digit and one quotient bit per cycle.
	always_comb begin
		rem_next = {rem_q[23:0], s_q[43:42]};
		trial    = {2'b00, root_q, 2'b01};
		rt       = {drem_q, dlow_q[15]};
		qbit     = rt >= {1'b0, root_q};
		qn       = {dq_q[14:0], qbit};
		qc       = (qn > UNIT) ? UNIT : qn;
		num      = {1'b0, sel_m[20:0], 14'd0} + {15'd0, root_q[21:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the done flag.
	always_comb begin
		state_d  = state_q;
		nrm_done = 1'b0;
		unique case (state_q)
			N_IDLE:  if (start) state_d = N_CHK;
			N_CHK: begin
				if (mx == '0) state_d = N_DONE;
				else if (mx < (MAG_W'(1) << 17)) state_d = N_DSQ;
				else state_d = N_SHIFT;
			end
			N_DSQ:   if (k_q == 2'd2) state_d = N_DCMP;
			N_DCMP:  state_d = (s_q <= {12'd0, thr}) ? N_DONE : N_SHIFT;
			N_SHIFT: begin
				if (mx < (MAG_W'(1) << 21) && mx >= (MAG_W'(1) << 20)) state_d = N_SQ;
			end
			N_SQ:    if (k_q == 2'd2) state_d = N_SQRT;
			N_SQRT:  if (cnt_q == 5'd21) state_d = N_DIVI;
			N_DIVI:  state_d = N_DIV;
			N_DIV:   if (cnt_q == 5'd15) state_d = (k_q == 2'd2) ? N_DONE : N_DIVI;
			N_DONE: begin
				nrm_done = 1'b1;
				state_d  = N_IDLE;
			end
			default: state_d = N_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					neg_q[0] <= cx[MAG_W-1];
					neg_q[1] <= cy[MAG_W-1];
					neg_q[2] <= cz[MAG_W-1];
					m_q[0]   <= cx[MAG_W-1] ? MAG_W'(-cx) : MAG_W'(cx);
					m_q[1]   <= cy[MAG_W-1] ? MAG_W'(-cy) : MAG_W'(cy);
					m_q[2]   <= cz[MAG_W-1] ? MAG_W'(-cz) : MAG_W'(cz);
					n_q[0]   <= '0;
					n_q[1]   <= '0;
					n_q[2]   <= '0;
				end
			end
			N_CHK: begin
				k_q <= 2'd0;
				s_q <= '0;
			end
			N_DSQ, N_SQ: begin
				s_q <= s_q + {2'b00, prod};
				k_q <= k_q + 2'd1;
				cnt_q  <= '0;
				root_q <= '0;
				rem_q  <= '0;
			end
			N_SHIFT: begin
				k_q <= 2'd0;
				s_q <= '0;
				if (mx >= (MAG_W'(1) << 21)) begin
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end else if (mx < (MAG_W'(1) << 20)) begin
					m_q[0] <= m_q[0] << 1;
					m_q[1] <= m_q[1] << 1;
					m_q[2] <= m_q[2] << 1;
				end
			end
			N_SQRT: begin
				s_q   <= s_q << 2;
				cnt_q <= cnt_q + 5'd1;
				k_q   <= 2'd0;
				if (rem_next >= trial) begin
					rem_q  <= rem_next - trial;
					root_q <= {root_q[20:0], 1'b1};
				end else begin
					rem_q  <= rem_next;
					root_q <= {root_q[20:0], 1'b0};
				end
			end
			N_DIVI: begin
				drem_q <= {2'b00, num[35:16]};
				dlow_q <= num[15:0];
				dq_q   <= '0;
				cnt_q  <= '0;
			end
			N_DIV: begin
				drem_q <= qbit ? 22'(rt - {1'b0, root_q}) : rt[21:0];
				dlow_q <= dlow_q << 1;
				dq_q   <= qn;
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					n_q[k_q] <= neg_q[k_q] ? NRM_W'(-qc) : qc;
					k_q      <= k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = {nrm_done, n_q[0], n_q[1], n_q[2]};

endmodule
`default_nettype wire

[sv/svn_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module svn_checker
	import svn_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic signed [NRM_W-1:0] normal_x,
	input wire logic signed [NRM_W-1:0] normal_y,
	input wire logic signed [NRM_W-1:0] normal_z,
	input wire logic                    status
);

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Items are taken one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

	// An error result carries a zero normal.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_ERR |->
		normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("error result with nonzero normal");

	// Components stay within unit length.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
		normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
		normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal component beyond unit");

endmodule

bind smooth_vertex_normals_core svn_checker u_svn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.normal_x  (normal_x),
	.normal_y  (normal_y),
	.normal_z  (normal_z),
	.status    (status)
);
`default_nettype wire
